[sv/storage_disk_select_table_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the disk selection table
// ---------------------------------------------------------------------------
`ifndef STORAGE_DISK_SELECT_TABLE_DEFINES_SVH
`define STORAGE_DISK_SELECT_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SDST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SDST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SDST_ASSERT(lbl, prop, msg)
`define SDST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/sdst_pkg.sv]
// ---------------------------------------------------------------------------
// sdst_pkg
// Types and constants shared by the disk selection table modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdst_pkg;

    localparam int FUNC_W  = 4;
    localparam int NUM_W   = 5;
    localparam int AMT_W   = 48;
    localparam int CAP_W   = 48;
    localparam int FREE_W  = 50;
    localparam int PEND_W  = 16;
    localparam int FC_W    = 32;
    localparam int FD_W    = 17;
    localparam int ST_W    = 2;
    localparam int MFS_W   = 41;
    localparam int WPD_W   = 8;
    localparam int THR_W   = 7;
    localparam int PROD_W  = 57;
    localparam int ROOM_W  = 59;
    localparam int TCAP_W  = 52;
    localparam int TUSED_W = 54;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 41;

    localparam logic [FUNC_W-1:0] FN_CLEAR   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_LOAD    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_PICK_W  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_PICK_M  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_USED    = 4'd4;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 4'd5;
    localparam logic [FUNC_W-1:0] FN_SHRINK  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_FILES   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_STATUS  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_TOTALS  = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_MFS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITERS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR     = 2'd2;

    localparam logic [ST_W-1:0] ST_NORMAL = 2'd0;

    localparam logic [MFS_W-1:0] MFS_RESET = 41'd268435456;
    localparam logic [WPD_W-1:0] WPD_RESET = 8'd1;
    localparam logic [THR_W-1:0] THR_RESET = 7'd80;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;
    localparam logic signed [FC_W-1:0] FC_MAX = 32'sh7fff_ffff;
    localparam logic signed [FC_W-1:0] FC_MIN = 32'sh8000_0000;
    localparam logic signed [FREE_W-1:0] FREE_MAX = {1'b0, {(FREE_W-1){1'b1}}};
    localparam logic signed [FREE_W-1:0] FREE_MIN = {1'b1, {(FREE_W-1){1'b0}}};
    localparam logic signed [TUSED_W-1:0] TUSED_MAX = {1'b0, {(TUSED_W-1){1'b1}}};
    localparam logic signed [TUSED_W-1:0] TUSED_MIN = {1'b1, {(TUSED_W-1){1'b0}}};
    localparam logic [TCAP_W-1:0] TCAP_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic walk_init;
        logic rd_walk;
        logic mul;
        logic room;
        logic eval;
        logic rd_target;
        logic fin;
    } sdst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_op;
        logic count_zero;
        logic walk_last;
        logic out_free;
    } sdst_stat_t;

endpackage

[sv/storage_disk_select_table.sv]
// ---------------------------------------------------------------------------
// storage_disk_select_table
// Disk table with write and migration target selection, updates and totals.
// ---------------------------------------------------------------------------
// Use:
//   Input channel in_valid/in_stall carries one operation beat (func, disk_no,
//   amount, capacity, decr_pending, file_delta, new_status). Output channel
//   out_valid/out_stall returns exactly one result beat per input beat.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata):
//   index 0 max_file_size, 1 writers_per_disk, 2 space_threshold_pct.
// Sequence:
//   Clear, load and unused codes skip the table walk. Operations that
//   walk the table visit each loaded disk in turn. Each entry takes a
//   memory read, the pending*max_file_size multiply, the room subtract
//   and the evaluation.
//   One beat in flight at a time; in_stall is high from accept until the
//   result is registered.
// Reset:
//   Empties the table and loads the default registers. No clearing pass: the
//   fill count bounds every walk.
// Stall:
//   A result waits in the output register while out_stall is high; the next
//   beat may be accepted meanwhile, its result held back until the slot frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "storage_disk_select_table_defines.svh"

module storage_disk_select_table
#(
    parameter int MAX_DISKS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sdst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sdst_pkg::CFG_DAT_W-1:0]        cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [sdst_pkg::FUNC_W-1:0]           func,
    input  logic [sdst_pkg::NUM_W-1:0]            disk_no,
    input  logic [sdst_pkg::AMT_W-1:0]            amount,
    input  logic [sdst_pkg::CAP_W-1:0]            capacity,
    input  logic                                  decr_pending,
    input  logic signed [sdst_pkg::FD_W-1:0]      file_delta,
    input  logic [sdst_pkg::ST_W-1:0]             new_status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sdst_pkg::NUM_W-1:0]            chosen_disk,
    output logic                                  ok,
    output logic                                  disk_normal,
    output logic [sdst_pkg::TCAP_W-1:0]           total_capacity,
    output logic signed [sdst_pkg::TUSED_W-1:0]   total_used
);

    sdst_pkg::sdst_cmd_t  cmd;   // sequencer commands
    sdst_pkg::sdst_stat_t stat;  // datapath status

    sdst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdst_dp #(.MAX_DISKS(MAX_DISKS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .func           (func),
        .disk_no        (disk_no),
        .amount         (amount),
        .capacity       (capacity),
        .decr_pending   (decr_pending),
        .file_delta     (file_delta),
        .new_status     (new_status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chosen_disk    (chosen_disk),
        .ok             (ok),
        .disk_normal    (disk_normal),
        .total_capacity (total_capacity),
        .total_used     (total_used)
    );

    // busy right after a beat is taken
    `SDST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not followed by busy")
    // finish always presents a result
    `SDST_ASSERT_NEXT(a_fin_gives_result, cmd.fin, out_valid, "finish without result")
    // capture, table reads and finish never overlap
    `SDST_ASSERT(a_cmd_exclusive, $onehot0({cmd.capture, cmd.rd_walk, cmd.rd_target, cmd.fin}), "commands overlap")

endmodule

[sv/sdst_ctrl.sv]
// ---------------------------------------------------------------------------
// sdst_ctrl
// Sequencer: capture, table walk (read, multiply, room, evaluate), finish.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sdst_pkg::sdst_stat_t stat,
    output sdst_pkg::sdst_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ROOM  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_POST  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                cmd.walk_init = 1'b1;
                state_next = (stat.walk_op && !stat.count_zero) ? S_RD : S_POST;
            end
            S_RD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ROOM;
            end
            S_ROOM:
            begin
                cmd.room   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.walk_last ? S_POST : S_RD;
            end
            S_POST:
            begin
                cmd.rd_target = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[sv/sdst_dp.sv]
// ---------------------------------------------------------------------------
// sdst_dp
// Table memories, configuration, walk trackers, update arithmetic, result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdst_dp
#(
    parameter int MAX_DISKS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sdst_pkg::sdst_cmd_t                   cmd,
    output sdst_pkg::sdst_stat_t                  stat,
    input  logic                                  cfg_we,
    input  logic [sdst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sdst_pkg::CFG_DAT_W-1:0]        cfg_wdata,
    input  logic [sdst_pkg::FUNC_W-1:0]           func,
    input  logic [sdst_pkg::NUM_W-1:0]            disk_no,
    input  logic [sdst_pkg::AMT_W-1:0]            amount,
    input  logic [sdst_pkg::CAP_W-1:0]            capacity,
    input  logic                                  decr_pending,
    input  logic signed [sdst_pkg::FD_W-1:0]      file_delta,
    input  logic [sdst_pkg::ST_W-1:0]             new_status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sdst_pkg::NUM_W-1:0]            chosen_disk,
    output logic                                  ok,
    output logic                                  disk_normal,
    output logic [sdst_pkg::TCAP_W-1:0]           total_capacity,
    output logic signed [sdst_pkg::TUSED_W-1:0]   total_used
);

    localparam int IW = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int CW = $clog2(MAX_DISKS + 1);

    // configuration
    logic [sdst_pkg::MFS_W-1:0] mfs_reg;
    logic [sdst_pkg::WPD_W-1:0] wpd_reg;
    logic [sdst_pkg::THR_W-1:0] thr_reg;

    // captured beat
    logic [sdst_pkg::FUNC_W-1:0]      func_reg;
    logic [sdst_pkg::NUM_W-1:0]       no_reg;
    logic [sdst_pkg::AMT_W-1:0]       amt_reg;
    logic [sdst_pkg::CAP_W-1:0]       cap_in_reg;
    logic                             decr_reg;
    logic signed [sdst_pkg::FD_W-1:0] fd_reg;
    logic [sdst_pkg::ST_W-1:0]        nst_reg;

    // table memories
    logic [sdst_pkg::NUM_W-1:0]         mem_num  [MAX_DISKS];
    logic [sdst_pkg::CAP_W-1:0]         mem_cap  [MAX_DISKS];
    logic signed [sdst_pkg::FREE_W-1:0] mem_free [MAX_DISKS];
    logic [sdst_pkg::PEND_W-1:0]        mem_pend [MAX_DISKS];
    logic signed [sdst_pkg::FC_W-1:0]   mem_fc   [MAX_DISKS];
    logic [sdst_pkg::ST_W-1:0]          mem_st   [MAX_DISKS];

    logic [sdst_pkg::NUM_W-1:0]         rd_num_reg;
    logic [sdst_pkg::CAP_W-1:0]         rd_cap_reg;
    logic signed [sdst_pkg::FREE_W-1:0] rd_free_reg;
    logic [sdst_pkg::PEND_W-1:0]        rd_pend_reg;
    logic signed [sdst_pkg::FC_W-1:0]   rd_fc_reg;
    logic [sdst_pkg::ST_W-1:0]          rd_st_reg;

    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [sdst_pkg::NUM_W-1:0] last_no_reg;
    logic [sdst_pkg::NUM_W-1:0] last_no_next;
    logic [CW-1:0]              walk_cnt_reg;

    // walk pipeline
    logic [sdst_pkg::PROD_W-1:0]        prod_reg;
    logic signed [sdst_pkg::ROOM_W-1:0] room_reg;

    // trackers
    logic                               any_v_reg, lim_v_reg, few_v_reg, found_reg, by_space_reg;
    logic [IW-1:0]                      any_i_reg, lim_i_reg, few_i_reg, found_i_reg;
    logic signed [sdst_pkg::ROOM_W-1:0] any_r_reg, lim_r_reg, few_r_reg;
    logic signed [sdst_pkg::FC_W-1:0]   few_n_reg;
    logic [sdst_pkg::TCAP_W-1:0]        tcap_reg;
    logic signed [sdst_pkg::TUSED_W-1:0] tused_reg;

    logic          tgt_found_reg;
    logic [IW-1:0] tgt_idx_reg;
    logic          tgt_found_next;
    logic [IW-1:0] tgt_idx_next;

    logic out_valid_reg;

    // -------- decode of captured beat --------
    logic no_valid;
    logic is_mig;
    logic [sdst_pkg::WPD_W-1:0] wpd_eff;

    assign no_valid = (no_reg != '0) && (32'(no_reg) <= MAX_DISKS);
    assign is_mig   = (func_reg == sdst_pkg::FN_PICK_M);
    assign wpd_eff  = (wpd_reg == '0) ? sdst_pkg::WPD_W'(1) : wpd_reg;

    assign stat.walk_op    = func_reg inside {[sdst_pkg::FN_PICK_W:sdst_pkg::FN_TOTALS]};
    assign stat.count_zero = (count_reg == '0);
    assign stat.walk_last  = ((walk_cnt_reg + CW'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // -------- walk evaluation --------
    logic signed [sdst_pkg::ROOM_W-1:0] mfs_room;
    logic                               qual, p_lt_w;
    logic signed [59:0]                 cap60, d60, u60, tu60;
    logic signed [67:0]                 d68, d100;
    logic [54:0]                        ct;
    logic                               over_thr;
    logic [sdst_pkg::TCAP_W:0]          tc53;
    logic signed [sdst_pkg::ROOM_W-1:0] room_next;

    assign mfs_room  = $signed({{(sdst_pkg::ROOM_W-sdst_pkg::MFS_W){1'b0}}, mfs_reg});
    assign room_next = $signed({{(sdst_pkg::ROOM_W-sdst_pkg::FREE_W){rd_free_reg[49]}},
                                rd_free_reg}) - $signed({2'b00, prod_reg});
    assign qual   = (rd_st_reg == sdst_pkg::ST_NORMAL) && (is_mig || room_reg >= mfs_room);
    assign p_lt_w = ({8'd0, rd_pend_reg} < {8'd0, wpd_eff, 8'd0} >> 8);
    assign cap60  = $signed({12'd0, rd_cap_reg});
    assign d60    = cap60 - $signed({room_reg[58], room_reg});
    assign d68    = {{8{d60[59]}}, d60};
    assign d100   = (d68 <<< 6) + (d68 <<< 5) + (d68 <<< 2);
    assign ct     = {7'd0, rd_cap_reg} * {48'd0, thr_reg};
    assign over_thr = d100 > $signed({13'd0, ct});
    assign u60    = cap60 - $signed({{10{rd_free_reg[49]}}, rd_free_reg})
                  + $signed({3'd0, prod_reg});
    assign tu60   = $signed({{6{tused_reg[53]}}, tused_reg}) + u60;
    assign tc53   = {1'b0, tcap_reg} + {5'd0, rd_cap_reg};

    // -------- target choice --------
    always_comb
    begin
        tgt_found_next = found_reg;
        tgt_idx_next   = found_i_reg;
        case (func_reg)
            sdst_pkg::FN_PICK_W:
            begin
                if (!by_space_reg && few_v_reg)
                begin
                    tgt_found_next = 1'b1;
                    tgt_idx_next   = few_i_reg;
                end
                else if (lim_v_reg)
                begin
                    tgt_found_next = 1'b1;
                    tgt_idx_next   = lim_i_reg;
                end
                else
                begin
                    tgt_found_next = any_v_reg;
                    tgt_idx_next   = any_i_reg;
                end
            end
            sdst_pkg::FN_PICK_M:
            begin
                tgt_found_next = any_v_reg;
                tgt_idx_next   = any_i_reg;
            end
            default:
            begin
            end
        endcase
    end

    // -------- finish: updates and result --------
    logic signed [sdst_pkg::FREE_W:0]   f_add, f_sub;
    logic signed [sdst_pkg::FREE_W-1:0] f_add_sat, f_sub_sat;
    logic signed [sdst_pkg::FC_W:0]     fc_sum;
    logic signed [sdst_pkg::FC_W-1:0]   fc_sat;
    logic free_ge, load_ok;

    assign f_add = {rd_free_reg[49], rd_free_reg} + $signed({3'd0, amt_reg});
    assign f_sub = {rd_free_reg[49], rd_free_reg} - $signed({3'd0, amt_reg});
    assign f_add_sat = (f_add[50] != f_add[49]) ?
                       (f_add[50] ? sdst_pkg::FREE_MIN : sdst_pkg::FREE_MAX) : f_add[49:0];
    assign f_sub_sat = (f_sub[50] != f_sub[49]) ?
                       (f_sub[50] ? sdst_pkg::FREE_MIN : sdst_pkg::FREE_MAX) : f_sub[49:0];
    assign fc_sum = {rd_fc_reg[31], rd_fc_reg} + {{16{fd_reg[16]}}, fd_reg};
    assign fc_sat = (fc_sum[32] != fc_sum[31]) ?
                    (fc_sum[32] ? sdst_pkg::FC_MIN : sdst_pkg::FC_MAX) : fc_sum[31:0];
    assign free_ge = rd_free_reg >= $signed({9'd0, mfs_reg});
    assign load_ok = no_valid && (count_reg != CW'(MAX_DISKS)) &&
                     ((count_reg == '0) || (no_reg > last_no_reg));

    logic                               we_all, we_free, we_pend, we_fc, we_st;
    logic [IW-1:0]                      w_idx;
    logic signed [sdst_pkg::FREE_W-1:0] w_free;
    logic [sdst_pkg::PEND_W-1:0]        w_pend;
    logic signed [sdst_pkg::FC_W-1:0]   w_fc;
    logic [sdst_pkg::NUM_W-1:0]         r_chosen;
    logic                               r_ok, r_normal;
    logic [sdst_pkg::TCAP_W-1:0]        r_tcap;
    logic signed [sdst_pkg::TUSED_W-1:0] r_tused;

    always_comb
    begin
        we_all = 1'b0; we_free = 1'b0; we_pend = 1'b0; we_fc = 1'b0; we_st = 1'b0;
        w_idx  = tgt_idx_reg;
        w_free = f_add_sat;
        w_pend = rd_pend_reg;
        w_fc   = fc_sat;
        r_chosen = '0; r_ok = 1'b0; r_normal = 1'b0; r_tcap = '0; r_tused = '0;
        count_next   = count_reg;
        last_no_next = last_no_reg;
        case (func_reg)
            sdst_pkg::FN_CLEAR:
            begin
                count_next   = '0;
                last_no_next = '0;
                r_ok = 1'b1;
            end
            sdst_pkg::FN_LOAD:
            begin
                if (load_ok)
                begin
                    we_all = 1'b1;
                    w_idx  = count_reg[IW-1:0];
                    count_next   = count_reg + CW'(1);
                    last_no_next = no_reg;
                    r_ok = 1'b1;
                end
            end
            sdst_pkg::FN_PICK_W, sdst_pkg::FN_PICK_M:
            begin
                if (tgt_found_reg && free_ge)
                begin
                    r_chosen = rd_num_reg;
                    r_ok     = 1'b1;
                    if (!is_mig && rd_pend_reg != sdst_pkg::PEND_MAX)
                    begin
                        we_pend = 1'b1;
                        w_pend  = rd_pend_reg + sdst_pkg::PEND_W'(1);
                    end
                end
            end
            sdst_pkg::FN_USED:
            begin
                if (tgt_found_reg)
                begin
                    r_ok = 1'b1;
                    if (decr_reg)
                    begin
                        we_free = 1'b1;
                        w_free  = f_sub_sat;
                        if (rd_pend_reg != '0)
                        begin
                            we_pend = 1'b1;
                            w_pend  = rd_pend_reg - sdst_pkg::PEND_W'(1);
                        end
                    end
                    if (amt_reg != '0 && rd_fc_reg != sdst_pkg::FC_MAX)
                    begin
                        we_fc = 1'b1;
                        w_fc  = rd_fc_reg + 32'sd1;
                    end
                end
            end
            sdst_pkg::FN_RELEASE:
            begin
                if (tgt_found_reg)
                begin
                    r_ok = 1'b1;
                    we_free = 1'b1;
                end
            end
            sdst_pkg::FN_SHRINK:
            begin
                if (tgt_found_reg)
                begin
                    r_ok = 1'b1;
                    we_free = 1'b1;
                    w_free  = f_sub_sat;
                end
            end
            sdst_pkg::FN_FILES:
            begin
                if (tgt_found_reg)
                begin
                    r_ok = 1'b1;
                    we_fc = 1'b1;
                end
            end
            sdst_pkg::FN_STATUS:
            begin
                if (tgt_found_reg)
                begin
                    r_ok = 1'b1;
                    we_st = 1'b1;
                end
            end
            sdst_pkg::FN_QUERY:
            begin
                if (tgt_found_reg)
                begin
                    r_ok     = 1'b1;
                    r_normal = (rd_st_reg == sdst_pkg::ST_NORMAL);
                end
            end
            sdst_pkg::FN_TOTALS:
            begin
                r_ok    = 1'b1;
                r_tcap  = tcap_reg;
                r_tused = tused_reg;
            end
            default:
            begin
            end
        endcase
    end

    // -------- memories --------
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    assign rd_en   = cmd.rd_walk || (cmd.rd_target && tgt_found_next);
    assign rd_addr = cmd.rd_walk ? walk_cnt_reg[IW-1:0] : tgt_idx_next;

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            if (we_all)
            begin
                mem_num[w_idx]  <= no_reg;
                mem_cap[w_idx]  <= cap_in_reg;
                mem_free[w_idx] <= $signed({2'b00, amt_reg});
                mem_pend[w_idx] <= '0;
                mem_fc[w_idx]   <= '0;
                mem_st[w_idx]   <= sdst_pkg::ST_NORMAL;
            end
            if (we_free)
                mem_free[w_idx] <= w_free;
            if (we_pend)
                mem_pend[w_idx] <= w_pend;
            if (we_fc)
                mem_fc[w_idx] <= w_fc;
            if (we_st)
                mem_st[w_idx] <= nst_reg;
        end
        if (rd_en)
        begin
            rd_num_reg  <= mem_num[rd_addr];
            rd_cap_reg  <= mem_cap[rd_addr];
            rd_free_reg <= mem_free[rd_addr];
            rd_pend_reg <= mem_pend[rd_addr];
            rd_fc_reg   <= mem_fc[rd_addr];
            rd_st_reg   <= mem_st[rd_addr];
        end
    end

    // -------- payload registers --------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            no_reg     <= disk_no;
            amt_reg    <= amount;
            cap_in_reg <= capacity;
            decr_reg   <= decr_pending;
            fd_reg     <= file_delta;
            nst_reg    <= new_status;
        end
        if (cmd.mul)
            prod_reg <= sdst_pkg::PROD_W'(rd_pend_reg) * sdst_pkg::PROD_W'(mfs_reg);
        if (cmd.room)
            room_reg <= room_next;
        if (cmd.walk_init)
        begin
            any_r_reg <= '0;
            lim_r_reg <= '0;
            few_r_reg <= '0;
            few_n_reg <= sdst_pkg::FC_MAX;
            tcap_reg  <= '0;
            tused_reg <= '0;
        end
        if (cmd.eval)
        begin
            if (qual && room_reg > any_r_reg)
            begin
                any_r_reg <= room_reg;
                any_i_reg <= walk_cnt_reg[IW-1:0];
            end
            if (qual && !is_mig && p_lt_w && room_reg > lim_r_reg)
            begin
                lim_r_reg <= room_reg;
                lim_i_reg <= walk_cnt_reg[IW-1:0];
            end
            if (qual && !is_mig && p_lt_w && rd_fc_reg <= few_n_reg &&
                (rd_fc_reg < few_n_reg || room_reg > few_r_reg))
            begin
                few_r_reg <= room_reg;
                few_n_reg <= rd_fc_reg;
                few_i_reg <= walk_cnt_reg[IW-1:0];
            end
            if (!found_reg && no_valid && rd_num_reg == no_reg)
                found_i_reg <= walk_cnt_reg[IW-1:0];
            tcap_reg <= tc53[sdst_pkg::TCAP_W] ? sdst_pkg::TCAP_MAX : tc53[sdst_pkg::TCAP_W-1:0];
            if (tu60 > $signed({{6{1'b0}}, sdst_pkg::TUSED_MAX}))
                tused_reg <= sdst_pkg::TUSED_MAX;
            else if (tu60 < $signed({{6{1'b1}}, sdst_pkg::TUSED_MIN}))
                tused_reg <= sdst_pkg::TUSED_MIN;
            else
                tused_reg <= tu60[sdst_pkg::TUSED_W-1:0];
        end
        if (cmd.rd_target)
            tgt_idx_reg <= tgt_idx_next;
        if (cmd.fin)
        begin
            chosen_disk    <= r_chosen;
            ok             <= r_ok;
            disk_normal    <= r_normal;
            total_capacity <= r_tcap;
            total_used     <= r_tused;
        end
    end

    // -------- control state --------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mfs_reg       <= sdst_pkg::MFS_RESET;
            wpd_reg       <= sdst_pkg::WPD_RESET;
            thr_reg       <= sdst_pkg::THR_RESET;
            count_reg     <= '0;
            last_no_reg   <= '0;
            walk_cnt_reg  <= '0;
            any_v_reg     <= 1'b0;
            lim_v_reg     <= 1'b0;
            few_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            by_space_reg  <= 1'b0;
            tgt_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sdst_pkg::CFG_MFS:     mfs_reg <= cfg_wdata;
                    sdst_pkg::CFG_WRITERS: wpd_reg <= cfg_wdata[sdst_pkg::WPD_W-1:0];
                    sdst_pkg::CFG_THR:     thr_reg <= cfg_wdata[sdst_pkg::THR_W-1:0];
                    default:               ;
                endcase
            end
            if (cmd.walk_init)
            begin
                walk_cnt_reg <= '0;
                any_v_reg    <= 1'b0;
                lim_v_reg    <= 1'b0;
                few_v_reg    <= 1'b0;
                found_reg    <= 1'b0;
                by_space_reg <= 1'b0;
            end
            if (cmd.eval)
            begin
                walk_cnt_reg <= walk_cnt_reg + CW'(1);
                if (qual && room_reg > any_r_reg)
                    any_v_reg <= 1'b1;
                if (qual && !is_mig && p_lt_w && room_reg > lim_r_reg)
                    lim_v_reg <= 1'b1;
                if (qual && !is_mig && p_lt_w && rd_fc_reg <= few_n_reg &&
                    (rd_fc_reg < few_n_reg || room_reg > few_r_reg))
                    few_v_reg <= 1'b1;
                if (qual && !is_mig && over_thr)
                    by_space_reg <= 1'b1;
                if (no_valid && rd_num_reg == no_reg)
                    found_reg <= 1'b1;
            end
            if (cmd.rd_target)
                tgt_found_reg <= tgt_found_next;
            if (cmd.fin)
            begin
                count_reg   <= count_next;
                last_no_reg <= last_no_next;
            end
            if (cmd.fin)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
